// ===== rtl/core/mfbs_pkg.sv =====
`timescale 1ns / 1ps

package mfbs_pkg;

    // Screen geometry. Each store byte holds eight vertically adjacent pixels.
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);

    // Stream payload layout.
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PEN_COLOR        = 1'b0;
    localparam logic REG_BACKGROUND_COLOR = 1'b1;
    localparam logic [15:0] PEN_COLOR_RESET        = 16'hFFFF;
    localparam logic [15:0] BACKGROUND_COLOR_RESET = 16'h0000;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_SCAN  = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_SET    = 2'd1,
        MODE_TOGGLE = 2'd2,
        MODE_KEEP   = 2'd3
    } pix_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rd_pixel;   // read byte under the incoming pixel, latch write target
        logic rd_scan;    // read byte under the scan position
        logic wr_rmw;     // write back the modified pixel byte
        logic wr_clear;   // write the fill byte at the sweep address
        logic load_fill;  // capture the incoming fill byte
        logic load_out;   // move the scanned pixel into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pix_ok;     // incoming pixel write lands on screen and its mode is not keep
        logic clr_last;   // sweep is at the last store byte
        logic out_free;   // output register can take a new transaction
    } dp_status_t;

endpackage

// ===== rtl/core/mono_framebuffer_rgb565_scanout_top.sv =====
`timescale 1ns / 1ps
// Page-organized 1-bit-per-pixel framebuffer with RGB565 scan-out.
// The slave stream carries commands: tuser selects a pixel write, a scan tick
// or a fill, and tdata carries the pixel coordinates, write mode and fill byte.
// The master stream returns one RGB565 color per scan tick, with tlast high
// on the last pixel of the frame. Writes and fills return nothing.
// The user must set pen and background colors through the APB port only while
// the block idles; the block itself does not enforce this. A pixel write reads
// the store byte and then writes it back from the RMW state; a write that falls
// off the screen or has the keep mode is taken without any store access. A scan
// tick reads the store byte on acceptance, and the scan state loads its result
// into the output register once that register is free; the single-port store
// read sets this sequence. A fill sweeps every store byte, one per cycle, and
// holds s_tready low until all 2560 bytes are written. After reset the same sweep
// clears the store to zero, and no transaction is accepted until it is done.
// When the receiver stalls, the result waits in the output register; writes
// and fills keep being accepted, and the next scan tick is accepted and read
// but waits until the output register frees before it completes.
// Reset returns the colors to white on black and the scan to the top left.

module mono_framebuffer_rgb565_scanout_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: pixel_x[7:0], pixel_y[15:8], pixel_mode[17:16], fill_byte[25:18],
    // zero above.
    input  logic [mfbs_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: op[1:0].
    input  logic [mfbs_pkg::S_TUSER_W-1:0]    s_tuser,
    // Pixel channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: pixel_color[15:0].
    output logic [mfbs_pkg::M_TDATA_W-1:0]    m_tdata,
    // tlast: frame_end.
    output logic                              m_tlast,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mfbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mfbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mfbs_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [15:0] pen_color;
    logic [15:0] background_color;

    // Color registers behind the APB port.
    mfbs_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .pen_color        (pen_color),
        .background_color (background_color)
    );

    // The controller sequences each transaction and the clearing sweep.
    mfbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the store, the scan position and the output register.
    mfbs_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tdata          (s_tdata),
        .cmd              (cmd),
        .status           (status),
        .pen_color        (pen_color),
        .background_color (background_color),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

endmodule

// ===== rtl/core/mfbs_apb_regs.sv =====
`timescale 1ns / 1ps

module mfbs_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mfbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mfbs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mfbs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [15:0]                        pen_color,
    output logic [15:0]                        background_color
);
    import mfbs_pkg::*;

    logic [15:0] pen_reg;
    logic [15:0] bg_reg;
    logic        reg_sel;
    logic        wr_en;

    // Registers sit on word boundaries, so the low address bits are ignored.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg <= PEN_COLOR_RESET;
            bg_reg  <= BACKGROUND_COLOR_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_PEN_COLOR) begin
                pen_reg <= pwdata[15:0];
            end else begin
                bg_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_PEN_COLOR) begin
            prdata = {{(APB_DATA_W-16){1'b0}}, pen_reg};
        end else begin
            prdata = {{(APB_DATA_W-16){1'b0}}, bg_reg};
        end
    end

    assign pen_color        = pen_reg;
    assign background_color = bg_reg;

endmodule

// ===== rtl/core/mfbs_ctrl.sv =====
`timescale 1ns / 1ps

module mfbs_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic [mfbs_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              s_tready,
    input  mfbs_pkg::dp_status_t              status,
    output mfbs_pkg::dp_cmd_t                 cmd
);
    import mfbs_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_clear = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (op_t'(s_tuser))
                        OP_PIXEL: begin
                            if (status.pix_ok) begin
                                cmd.rd_pixel = 1'b1;
                                state_next   = ST_RMW;
                            end
                        end
                        OP_SCAN: begin
                            cmd.rd_scan = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        OP_FILL: begin
                            cmd.load_fill = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                cmd.wr_rmw = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mfbs_datapath.sv =====
`timescale 1ns / 1ps

module mfbs_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mfbs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  mfbs_pkg::dp_cmd_t                 cmd,
    output mfbs_pkg::dp_status_t              status,
    input  logic [15:0]                       pen_color,
    input  logic [15:0]                       background_color,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfbs_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import mfbs_pkg::*;

    logic [7:0]        mem [STORE_BYTES];

    logic [7:0]        pix_x;
    logic [7:0]        pix_y;
    pix_mode_t         pix_mode;
    logic [7:0]        fill_byte;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rmw_byte;
    logic [7:0]        bit_mask;
    logic              last_col;
    logic              last_row;
    logic              lit;

    logic [ADDR_W-1:0] wr_addr_reg;
    logic [2:0]        bit_reg;
    pix_mode_t         mode_reg;
    logic [7:0]        clear_byte_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [7:0]        rd_data_reg;
    logic [COL_W-1:0]  scan_col_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [15:0]       out_color_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    assign pix_x     = s_tdata[7:0];
    assign pix_y     = s_tdata[15:8];
    assign pix_mode  = pix_mode_t'(s_tdata[17:16]);
    assign fill_byte = s_tdata[25:18];

    assign pix_addr  = ADDR_W'(pix_y >> 3) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pix_x);
    assign scan_addr = ADDR_W'(scan_row_reg >> 3) * ADDR_W'(SCREEN_WIDTH)
                       + ADDR_W'(scan_col_reg);

    assign status.pix_ok   = ({1'b0, pix_x} < 9'(SCREEN_WIDTH))
                          && ({1'b0, pix_y} < 9'(SCREEN_HEIGHT))
                          && (pix_mode != MODE_KEEP);
    assign status.clr_last = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    // Read-modify-write of one pixel bit.
    assign bit_mask = 8'd1 << bit_reg;
    always_comb begin
        case (mode_reg)
            MODE_CLEAR:  rmw_byte = rd_data_reg & ~bit_mask;
            MODE_SET:    rmw_byte = rd_data_reg | bit_mask;
            MODE_TOGGLE: rmw_byte = rd_data_reg ^ bit_mask;
            default:     rmw_byte = rd_data_reg;
        endcase
    end

    assign rd_addr = cmd.rd_scan ? scan_addr : pix_addr;
    assign wr_addr = cmd.wr_clear ? clr_addr_reg : wr_addr_reg;
    assign wr_data = cmd.wr_clear ? clear_byte_reg : rmw_byte;

    always_ff @(posedge aclk) begin
        if (cmd.wr_clear || cmd.wr_rmw) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_scan || cmd.rd_pixel) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_pixel) begin
            wr_addr_reg <= pix_addr;
            bit_reg     <= pix_y[2:0];
            mode_reg    <= pix_mode;
        end
    end

    // Sweep address and fill value; reset sweeps zeros through the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            clear_byte_reg <= '0;
        end else begin
            if (cmd.load_fill) begin
                clear_byte_reg <= fill_byte;
            end
            if (cmd.wr_clear) begin
                clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + 1'b1;
            end
        end
    end

    assign last_col = (scan_col_reg == COL_W'(SCREEN_WIDTH - 1));
    assign last_row = (scan_row_reg == ROW_W'(SCREEN_HEIGHT - 1));
    assign lit      = rd_data_reg[scan_row_reg[2:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
                if (last_col) begin
                    scan_col_reg <= '0;
                    scan_row_reg <= last_row ? '0 : scan_row_reg + 1'b1;
                end else begin
                    scan_col_reg <= scan_col_reg + 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_color_reg <= lit ? pen_color : background_color;
            out_last_reg  <= last_col && last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/mfbs_checker.sv =====
`timescale 1ns / 1ps

module mfbs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [mfbs_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mfbs_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tlast
);
    import mfbs_pkg::*;

    // Reset starts the clearing sweep, so no command is taken right after it.
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("command accepted during the reset clearing sweep");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("pixel presented right after reset");

    // A stalled pixel keeps its color and frame marker.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel changed");

    // A fill occupies the store, so the next cycle takes no command.
    a_fill_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_FILL) |=> !s_tready)
        else $error("command accepted while a fill sweeps the store");

    // A scan tick cannot finish before its store read returns.
    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_SCAN) |=> !s_tready)
        else $error("command accepted while a scan tick is in flight");

endmodule

bind mono_framebuffer_rgb565_scanout_top mfbs_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/tb_mono_framebuffer_rgb565_scanout_top.sv =====
`timescale 1ns / 1ps

module tb_mono_framebuffer_rgb565_scanout_top;
    import mfbs_pkg::*;

    // A fill or the clearing sweep after reset touches every store byte once.
    // Writes cause no result, so this many cycles are let pass before any
    // register write to be sure the block has finished its last command.
    localparam int SETTLE_CYCLES   = STORE_BYTES + 64;
    // The longest correct stretch without any transaction is one sweep
    // followed by the settle pause, so several times that means a hang.
    localparam int WATCHDOG_LIMIT  = 4 * STORE_BYTES + 1000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int LONG_SCAN_TICKS = 300;
    localparam int PHASE_COMMANDS  = 230;

    localparam logic [APB_ADDR_W-1:0] ADDR_PEN = {REG_PEN_COLOR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_BG  = {REG_BACKGROUND_COLOR, 2'b00};

    // One scanned pixel as the block should return it.
    typedef struct packed {
        logic [15:0] color;
        logic        last;
    } pixel_exp_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata: pixel_x[7:0], pixel_y[15:8], pixel_mode[17:16], fill_byte[25:18].
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // s_tuser: op[1:0].
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: pixel_color[15:0].
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the frame store, the scan position and the two colors. They
    // are updated in the order in which the block accepts its transactions.
    bit [7:0]        screen_bytes [STORE_BYTES];
    bit [COL_W-1:0]  beam_col;
    bit [ROW_W-1:0]  beam_row;
    bit [15:0]       pen_color;
    bit [15:0]       back_color;

    pixel_exp_t      pending_pixels[$];
    int              fail_count    = 0;
    int              pixels_taken  = 0;
    int              quiet_cycles  = 0;
    bit              idle_on       = 1'b1;
    bit              hold_req      = 1'b0;

    mono_framebuffer_rgb565_scanout_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Reset is held from the start, released once and never asserted again.
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Applies one accepted command to the shadow state. A scan tick produces
    // the color under the beam and then moves the beam in row-major order,
    // wrapping to the top left after the last pixel of the frame.
    function automatic void apply_command(op_t op, bit [7:0] x, bit [7:0] y,
                                          pix_mode_t mode, bit [7:0] fill);
        int         idx;
        pixel_exp_t want;
        bit         lit;
        case (op)
            OP_PIXEL: begin
                // Anything off the screen is dropped, even when the byte
                // index would still land inside the store.
                if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
                    idx = int'(y >> 3) * SCREEN_WIDTH + int'(x);
                    case (mode)
                        MODE_CLEAR:  screen_bytes[idx][y[2:0]] = 1'b0;
                        MODE_SET:    screen_bytes[idx][y[2:0]] = 1'b1;
                        MODE_TOGGLE: screen_bytes[idx][y[2:0]] = ~screen_bytes[idx][y[2:0]];
                        default: ;
                    endcase
                end
            end
            OP_FILL: begin
                foreach (screen_bytes[i]) screen_bytes[i] = fill;
            end
            OP_SCAN: begin
                idx        = int'(beam_row >> 3) * SCREEN_WIDTH + int'(beam_col);
                lit        = screen_bytes[idx][beam_row[2:0]];
                want.color = lit ? pen_color : back_color;
                want.last  = (beam_col == SCREEN_WIDTH - 1) && (beam_row == SCREEN_HEIGHT - 1);
                pending_pixels.push_back(want);
                if (beam_col == SCREEN_WIDTH - 1) begin
                    beam_col = '0;
                    beam_row = (beam_row == SCREEN_HEIGHT - 1) ? '0 : beam_row + 1'b1;
                end else begin
                    beam_col = beam_col + 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one command, after a random gap while idling is on, and returns once it
    // is accepted. The valid stays high after acceptance; the next call either lowers it
    // for a gap or replaces the payload, so it only moves once per edge.
    task automatic send_command(op_t op, bit [7:0] x, bit [7:0] y,
                                pix_mode_t mode, bit [7:0] fill);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, fill, mode, y, x};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        apply_command(op, x, y, mode, fill);
    endtask

    task automatic send_random_command();
        int        r;
        bit [7:0]  x;
        bit [7:0]  y;
        pix_mode_t mode;
        bit [7:0]  fill;
        r    = $urandom_range(0, 999);
        x    = $urandom_range(0, 255);
        y    = $urandom_range(0, 255);
        mode = pix_mode_t'($urandom_range(0, 3));
        fill = $urandom_range(0, 255);
        if (r < 8) begin
            send_command(OP_FILL, x, y, mode, fill);
        end else if (r < 30) begin
            send_command(OP_NONE, x, y, mode, fill);
        end else if (r < 530) begin
            send_command(OP_SCAN, x, y, mode, fill);
        end else if (r < 880) begin
            // Writes just ahead of the beam, so that later ticks read them.
            x = $urandom_range(0, SCREEN_WIDTH - 1);
            y = beam_row + $urandom_range(0, 2);
            send_command(OP_PIXEL, x, y, mode, fill);
        end else begin
            send_command(OP_PIXEL, x, y, mode, fill);
        end
    endtask

    // Lowers the command valid and waits until every scanned pixel has come
    // back, then lets a whole sweep pass in case a fill is still running.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PEN) pen_color = value;
        else back_color = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(logic [APB_ADDR_W-1:0] addr, logic [15:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'd0, want}) report_mismatch("register read", prdata, want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_colors(logic [15:0] pen, logic [15:0] back);
        wait_quiet();
        apb_write(ADDR_PEN, pen);
        apb_write(ADDR_BG, back);
        apb_read_check(ADDR_PEN, pen);
        apb_read_check(ADDR_BG, back);
    endtask

    // The registers come out of reset as white on black and then take both
    // extremes; the last setting here stays for the pixel mode test.
    task automatic test_registers();
        wait_quiet();
        apb_read_check(ADDR_PEN, PEN_COLOR_RESET);
        apb_read_check(ADDR_BG, BACKGROUND_COLOR_RESET);
        set_colors(16'hFFFF, 16'h0000);
        set_colors(16'h0000, 16'hFFFF);
    endtask

    // Every write mode on the first row, writes that fall off the screen, an
    // unknown command, then ticks that scan the touched pixels of the first row.
    task automatic test_pixel_modes();
        send_command(OP_PIXEL, 8'd0, 8'd0, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd1, 8'd0, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd1, 8'd0, MODE_TOGGLE, 8'h00);
        send_command(OP_PIXEL, 8'd2, 8'd0, MODE_TOGGLE, 8'h00);
        send_command(OP_PIXEL, 8'd3, 8'd0, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd3, 8'd0, MODE_CLEAR, 8'h00);
        send_command(OP_PIXEL, 8'd4, 8'd0, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd4, 8'd0, MODE_KEEP, 8'h00);
        send_command(OP_PIXEL, 8'd5, 8'd0, MODE_KEEP, 8'h00);
        send_command(OP_PIXEL, 8'd128, 8'd0, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd6, 8'd160, MODE_SET, 8'h00);
        send_command(OP_PIXEL, 8'd255, 8'd255, MODE_SET, 8'hFF);
        send_command(OP_PIXEL, 8'd127, 8'd159, MODE_SET, 8'h00);
        send_command(OP_NONE, 8'd7, 8'd0, MODE_SET, 8'hFF);
        repeat (9) send_command(OP_SCAN, 8'd0, 8'd0, MODE_CLEAR, 8'h00);
    endtask

    // Fills hold the command channel for a whole sweep; the writes queued
    // behind them must land after the sweep, not be overwritten by it.
    task automatic test_fill();
        send_command(OP_FILL, 8'd0, 8'd0, MODE_CLEAR, 8'hA5);
        send_command(OP_PIXEL, beam_col + 8'd1, beam_row, MODE_CLEAR, 8'h00);
        repeat (4) send_command(OP_SCAN, 8'd0, 8'd0, MODE_CLEAR, 8'h00);
        send_command(OP_FILL, 8'd0, 8'd0, MODE_CLEAR, 8'h5A);
        repeat (4) send_command(OP_SCAN, 8'd0, 8'd0, MODE_CLEAR, 8'h00);
    endtask

    // Scans a long run of pixels with no idling on either side, over a
    // random pattern plus a few marked pixels and a write just off the edge.
    task automatic test_long_scan();
        set_colors($urandom_range(0, 16'h7FFF), $urandom_range(16'h8000, 16'hFFFF));
        send_command(OP_FILL, 8'd0, 8'd0, MODE_CLEAR, $urandom_range(0, 255));
        send_command(OP_PIXEL, 8'd127, 8'd159, MODE_TOGGLE, 8'h00);
        send_command(OP_PIXEL, 8'd0, 8'd0, MODE_TOGGLE, 8'h00);
        send_command(OP_PIXEL, 8'd128, 8'd8, MODE_SET, 8'h00);
        repeat (12) begin
            send_command(OP_PIXEL, $urandom_range(0, SCREEN_WIDTH - 1),
                         $urandom_range(0, SCREEN_HEIGHT - 1),
                         pix_mode_t'($urandom_range(0, 3)), 8'h00);
        end
        idle_on = 1'b0;
        repeat (LONG_SCAN_TICKS) send_command(OP_SCAN, 8'd0, 8'd0, MODE_CLEAR, 8'h00);
        idle_on = 1'b1;
    endtask

    // The receiver stops for a long stretch while commands keep coming, so
    // the output register and the pending tick fill up and the input stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (2) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                send_command(OP_PIXEL, $urandom_range(0, SCREEN_WIDTH - 1), beam_row,
                             pix_mode_t'($urandom_range(0, 3)), 8'h00);
            else
                send_command(OP_SCAN, 8'd0, 8'd0, MODE_CLEAR, 8'h00);
        end
    endtask

    // Random traffic in several color phases, the first two at the extremes.
    task automatic test_random_traffic();
        logic [15:0] pen;
        logic [15:0] back;
        for (int phase = 0; phase < 5; phase++) begin
            pen  = $urandom_range(0, 16'hFFFF);
            back = $urandom_range(0, 16'hFFFF);
            if (back == pen) back = ~pen;
            if (phase == 0) begin
                pen  = 16'h0000;
                back = 16'hFFFF;
            end else if (phase == 1) begin
                pen  = 16'hFFFF;
                back = 16'h0000;
            end
            set_colors(pen, back);
            repeat (PHASE_COMMANDS) send_random_command();
        end
    endtask

    // While idling is on, the receiver draws a short stall after every pixel it takes,
    // and on request holds off for a long stretch that it counts down itself.
    initial begin : pixel_sink
        int stall;
        int hold;
        int seen;
        stall = 0;
        hold  = 0;
        seen  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold     = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            if (pixels_taken != seen) begin
                seen  = pixels_taken;
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every returned pixel is matched against the oldest expected one.
    always @(posedge aclk) begin : pixel_check
        pixel_exp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            pixels_taken <= pixels_taken + 1;
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with no scan tick pending", m_tdata, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata !== want.color) report_mismatch("pixel_color", m_tdata, want.color);
                if (m_tlast !== want.last) report_mismatch("frame_end", m_tlast, want.last);
            end
        end
    end

    // Any transaction on any port counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mono_framebuffer_rgb565_scanout_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pen_color  = PEN_COLOR_RESET;
        back_color = BACKGROUND_COLOR_RESET;
        beam_col   = '0;
        beam_row   = '0;
        foreach (screen_bytes[i]) screen_bytes[i] = 8'h00;
        @(posedge aresetn);
        test_registers();
        test_pixel_modes();
        test_fill();
        test_long_scan();
        test_backpressure();
        test_random_traffic();
        wait_quiet();
        if (fail_count == 0 && pending_pixels.size() == 0) begin
            $display("mono_framebuffer_rgb565_scanout_top regression: pass");
        end else begin
            $display("mono_framebuffer_rgb565_scanout_top regression: fail");
        end
        $finish;
    end

endmodule
